// ===== rtl/core/lru_cache_with_expiry_unit_defines.svh =====
// assertion macros for the lru cache with expiry unit
// used by the rtl files that carry concurrent checks, no other dependencies
`ifndef LRU_CACHE_WITH_EXPIRY_UNIT_DEFINES_SVH
`define LRU_CACHE_WITH_EXPIRY_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define LCE_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("lce check failed: %m");
`define LCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lce check failed: %m");
`define LCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lce check failed: %m");
`else
`define LCE_ASSERT(lbl, clk, rst_n, cond)
`define LCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/lce_pkg.sv =====
// shared constants, codes and helpers of the lru cache with expiry unit
// no dependencies
package lce_pkg;

    localparam int DEF_CAPACITY  = 64;
    localparam int DEF_KEY_BITS  = 64;
    localparam int DEF_DATA_BITS = 64;

    localparam int TIME_W    = 32;
    localparam int LIMIT_W   = 7;
    localparam int CNT_OUT_W = 7;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int KIND_W    = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUT   = 3'd0,
        KIND_GET   = 3'd1,
        KIND_DEL   = 3'd2,
        KIND_CLEAN = 3'd3,
        KIND_FLUSH = 3'd4
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIMIT    = 2'd0,
        CFG_EXPIRY   = 2'd1,
        CFG_NO_TOUCH = 2'd2
    } t_cfg_idx;

    function automatic logic is_stale(input logic [TIME_W-1:0] stamp,
                                      input logic [TIME_W-1:0] expiry,
                                      input logic [TIME_W-1:0] now);
        logic [TIME_W:0] sum;
        sum = {1'b0, stamp} + {1'b0, expiry};
        return (expiry != '0) && (sum < {1'b0, now});
    endfunction

    function automatic logic [CNT_OUT_W-1:0] sat_count(input logic [31:0] v);
        return (v > 32'd127) ? 7'd127 : v[CNT_OUT_W-1:0];
    endfunction

endpackage

// ===== rtl/core/lce_entry_store.sv =====
// entry memory of the cache: key, data and last-access stamp per slot
// depends on lce_pkg
module lce_entry_store #(
    parameter int DEPTH     = 64,
    parameter int KEY_BITS  = 64,
    parameter int DATA_BITS = 64
) (
    input  logic                        i_clk,
    input  logic [$clog2(DEPTH)-1:0]    i_rd_addr,
    input  logic                        i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]    i_wr_addr,
    input  logic [KEY_BITS-1:0]         i_wr_key,
    input  logic [DATA_BITS-1:0]        i_wr_data,
    input  logic [lce_pkg::TIME_W-1:0]  i_wr_stamp,
    input  logic [KEY_BITS-1:0]         i_cmp_key,
    output logic                        o_key_eq,
    output logic [DATA_BITS-1:0]        o_rd_data,
    output logic [lce_pkg::TIME_W-1:0]  o_rd_stamp
);
    import lce_pkg::*;

    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [DATA_BITS-1:0] data;
        logic [TIME_W-1:0]    stamp;
    } t_entry;

    t_entry r_mem [DEPTH];
    t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= '{key: i_wr_key, data: i_wr_data, stamp: i_wr_stamp};
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_key_eq   = (r_rd.key == i_cmp_key);
    assign o_rd_data  = r_rd.data;
    assign o_rd_stamp = r_rd.stamp;

endmodule

// ===== rtl/core/lce_link_store.sv =====
// lru order links of the cache: previous and next slot per slot, field write enables
// no dependencies
module lce_link_store #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic                     i_we_prev,
    input  logic                     i_we_next,
    input  logic [$clog2(DEPTH)-1:0] i_wr_prev,
    input  logic [$clog2(DEPTH)-1:0] i_wr_next,
    output logic [$clog2(DEPTH)-1:0] o_rd_prev,
    output logic [$clog2(DEPTH)-1:0] o_rd_next
);
    localparam int IW = $clog2(DEPTH);

    logic [IW-1:0] r_prev_mem [DEPTH];
    logic [IW-1:0] r_next_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we_prev) begin
            r_prev_mem[i_wr_addr] <= i_wr_prev;
        end
        if (i_we_next) begin
            r_next_mem[i_wr_addr] <= i_wr_next;
        end
        o_rd_prev <= r_prev_mem[i_rd_addr];
        o_rd_next <= r_next_mem[i_rd_addr];
    end

endmodule

// ===== rtl/core/lru_cache_with_expiry_unit.sv =====
// top level of the lru cache with expiry: request sequencer, valid map, lru list ends
// depends on lce_pkg, lce_entry_store, lce_link_store and the defines header
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------------
//   request  | start, busy          | i_kind, i_key, i_value, i_now
//   result   | o_done (one cycle)   | o_key_present, o_hit, o_read_value,
//            |                      | o_removed_count, o_occupancy
//   config   | i_cfg_we             | i_cfg_idx, i_cfg_wdata
//
// put, get and delete scan the entry memory, then pass a dispatch and a finish state;
// each entry unlinked, a link at the front, each limit check and each age check add
// states in between. clean skips the scan (dispatch, checks, finish); flush goes
// from dispatch straight to finish.
// busy is high from the cycle after start until the result strobe; the result is
// registered, and the next request may start in the strobe cycle.
// reset clears the valid map, the occupancy and the configuration.
`include "lru_cache_with_expiry_unit_defines.svh"
module lru_cache_with_expiry_unit #(
    parameter int CAPACITY  = lce_pkg::DEF_CAPACITY,
    parameter int KEY_BITS  = lce_pkg::DEF_KEY_BITS,
    parameter int DATA_BITS = lce_pkg::DEF_DATA_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [lce_pkg::KIND_W-1:0]     i_kind,
    input  logic [KEY_BITS-1:0]            i_key,
    input  logic [DATA_BITS-1:0]           i_value,
    input  logic [lce_pkg::TIME_W-1:0]     i_now,
    input  logic                           i_cfg_we,
    input  logic [lce_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lce_pkg::CFG_W-1:0]      i_cfg_wdata,
    output logic                           o_done,
    output logic                           o_key_present,
    output logic                           o_hit,
    output logic [DATA_BITS-1:0]           o_read_value,
    output logic [lce_pkg::CNT_OUT_W-1:0]  o_removed_count,
    output logic [lce_pkg::CNT_OUT_W-1:0]  o_occupancy
);
    import lce_pkg::*;

    localparam int IW   = $clog2(CAPACITY);
    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam int RMW  = CNTW + 1;
    localparam logic [IW:0]     SCAN_END = (IW+1)'(CAPACITY);
    localparam logic [CNTW-1:0] CNT_FULL = CNTW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DISP, S_UL_RD, S_UL_WAIT, S_UL_N, S_PUT_EV, S_PF, S_PF2,
        S_TOUCH, S_TRIM, S_AGE_RD, S_AGE_WAIT, S_FIN
    } t_state;

    t_state              r_state;
    t_state              r_ret;
    logic [CAPACITY-1:0] r_valid;
    logic [CNTW-1:0]     r_count;
    logic [IW-1:0]       r_head, r_tail;
    logic [LIMIT_W-1:0]  r_limit;
    logic [TIME_W-1:0]   r_expiry;
    logic                r_no_touch;

    t_kind               r_kind;
    logic [KEY_BITS-1:0] r_key;
    logic [DATA_BITS-1:0] r_val;
    logic [TIME_W-1:0]   r_now;
    logic [IW:0]         r_scan;
    logic                r_rv;
    logic [IW-1:0]       r_ridx;
    logic                r_mf, r_ff;
    logic [IW-1:0]       r_ms, r_fs;
    logic [TIME_W-1:0]   r_mstamp;
    logic [DATA_BITS-1:0] r_mdata;
    logic [IW-1:0]       r_us, r_ins, r_p, r_n;
    logic [RMW-1:0]      r_removed;
    logic                r_present, r_hitf;
    logic [DATA_BITS-1:0] r_rdata;

    logic                 r_o_key_present, r_o_hit;
    logic [DATA_BITS-1:0] r_o_read_value;
    logic [CNT_OUT_W-1:0] r_o_removed, r_o_occ;

    logic [IW-1:0]       ent_rd_addr;
    logic                ent_we;
    logic                ent_key_eq;
    logic [DATA_BITS-1:0] ent_rd_data;
    logic [TIME_W-1:0]   ent_rd_stamp;
    logic [IW-1:0]       lk_wr_addr, lk_wr_prev, lk_wr_next, lk_rd_prev, lk_rd_next;
    logic                lk_we_prev, lk_we_next;
    logic                trim_need;

    lce_entry_store #(
        .DEPTH(CAPACITY), .KEY_BITS(KEY_BITS), .DATA_BITS(DATA_BITS)
    ) u_entry (
        .i_clk      (i_clk),
        .i_rd_addr  (ent_rd_addr),
        .i_wr_en    (ent_we),
        .i_wr_addr  (r_ins),
        .i_wr_key   (r_key),
        .i_wr_data  (r_val),
        .i_wr_stamp (r_now),
        .i_cmp_key  (r_key),
        .o_key_eq   (ent_key_eq),
        .o_rd_data  (ent_rd_data),
        .o_rd_stamp (ent_rd_stamp)
    );

    lce_link_store #(.DEPTH(CAPACITY)) u_link (
        .i_clk     (i_clk),
        .i_rd_addr (r_us),
        .i_wr_addr (lk_wr_addr),
        .i_we_prev (lk_we_prev),
        .i_we_next (lk_we_next),
        .i_wr_prev (lk_wr_prev),
        .i_wr_next (lk_wr_next),
        .o_rd_prev (lk_rd_prev),
        .o_rd_next (lk_rd_next)
    );

    assign ent_rd_addr = (r_state == S_SCAN) ? r_scan[IW-1:0] : r_tail;
    assign ent_we      = (r_state == S_PF);
    assign trim_need   = (r_limit != '0) && (32'(r_count) > 32'(r_limit));

    always_comb begin
        lk_we_prev = 1'b0;
        lk_we_next = 1'b0;
        lk_wr_addr = r_ins;
        lk_wr_prev = r_ins;
        lk_wr_next = r_head;
        unique case (r_state)
            S_UL_WAIT: begin
                lk_we_next = (r_us != r_head);
                lk_wr_addr = lk_rd_prev;
                lk_wr_next = lk_rd_next;
            end
            S_UL_N: begin
                lk_we_prev = (r_us != r_tail);
                lk_wr_addr = r_n;
                lk_wr_prev = r_p;
            end
            S_PF: begin
                lk_we_next = 1'b1;
                lk_wr_addr = r_ins;
                lk_wr_next = r_head;
            end
            S_PF2: begin
                lk_we_prev = (r_count != '0);
                lk_wr_addr = r_head;
                lk_wr_prev = r_ins;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_count    <= '0;
            r_limit    <= '0;
            r_expiry   <= '0;
            r_no_touch <= 1'b0;
            o_done     <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LIMIT:    r_limit    <= i_cfg_wdata[LIMIT_W-1:0];
                    CFG_EXPIRY:   r_expiry   <= i_cfg_wdata[TIME_W-1:0];
                    CFG_NO_TOUCH: r_no_touch <= i_cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_kind    <= t_kind'(i_kind);
                        r_key     <= i_key;
                        r_val     <= i_value;
                        r_now     <= i_now;
                        r_mf      <= 1'b0;
                        r_ff      <= 1'b0;
                        r_removed <= '0;
                        r_present <= 1'b0;
                        r_hitf    <= 1'b0;
                        r_rdata   <= '0;
                        r_scan    <= '0;
                        r_rv      <= 1'b0;
                        case (t_kind'(i_kind)) inside
                            KIND_PUT, KIND_GET, KIND_DEL: r_state <= S_SCAN;
                            default:                      r_state <= S_DISP;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_scan != SCAN_END) begin
                        r_scan <= r_scan + 1'b1;
                    end
                    r_rv   <= (r_scan != SCAN_END);
                    r_ridx <= r_scan[IW-1:0];
                    if (r_rv) begin
                        if (r_valid[r_ridx] && ent_key_eq && !r_mf) begin
                            r_mf     <= 1'b1;
                            r_ms     <= r_ridx;
                            r_mstamp <= ent_rd_stamp;
                            r_mdata  <= ent_rd_data;
                        end
                        if (!r_valid[r_ridx] && !r_ff) begin
                            r_ff <= 1'b1;
                            r_fs <= r_ridx;
                        end
                    end
                    if (r_scan == SCAN_END && !r_rv) begin
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    case (r_kind)
                        KIND_PUT: begin
                            if (r_mf) begin
                                r_us    <= r_ms;
                                r_ret   <= S_PUT_EV;
                                r_state <= S_UL_RD;
                            end else begin
                                r_state <= S_PUT_EV;
                            end
                        end
                        KIND_GET: begin
                            if (r_mf) begin
                                r_present <= 1'b1;
                                r_us      <= r_ms;
                                if (is_stale(r_mstamp, r_expiry, r_now)) begin
                                    r_removed <= RMW'(1);
                                    r_ret     <= S_FIN;
                                    r_state   <= S_UL_RD;
                                end else begin
                                    r_hitf  <= 1'b1;
                                    r_rdata <= r_mdata;
                                    r_val   <= r_mdata;
                                    r_ret   <= S_TOUCH;
                                    r_state <= r_no_touch ? S_FIN : S_UL_RD;
                                end
                            end else begin
                                r_state <= S_FIN;
                            end
                        end
                        KIND_DEL: begin
                            if (r_mf) begin
                                r_us      <= r_ms;
                                r_removed <= RMW'(1);
                                r_ret     <= S_FIN;
                                r_state   <= S_UL_RD;
                            end else begin
                                r_state <= S_FIN;
                            end
                        end
                        KIND_CLEAN: r_state <= S_TRIM;
                        KIND_FLUSH: begin
                            r_removed <= RMW'(r_count);
                            r_valid   <= '0;
                            r_count   <= '0;
                            r_state   <= S_FIN;
                        end
                        default: r_state <= S_FIN;
                    endcase
                end
                S_UL_RD: r_state <= S_UL_WAIT;
                S_UL_WAIT: begin
                    r_p <= lk_rd_prev;
                    r_n <= lk_rd_next;
                    if (r_us == r_head) begin
                        r_head <= lk_rd_next;
                    end
                    r_state <= S_UL_N;
                end
                S_UL_N: begin
                    if (r_us == r_tail) begin
                        r_tail <= r_p;
                    end
                    r_valid[r_us] <= 1'b0;
                    r_count       <= r_count - 1'b1;
                    r_state       <= r_ret;
                end
                S_PUT_EV: begin
                    if (r_count == CNT_FULL) begin
                        r_us      <= r_tail;
                        r_ins     <= r_tail;
                        r_removed <= r_removed + 1'b1;
                        r_ret     <= S_PF;
                        r_state   <= S_UL_RD;
                    end else begin
                        r_ins   <= r_mf ? r_ms : r_fs;
                        r_state <= S_PF;
                    end
                end
                S_TOUCH: begin
                    r_ins   <= r_ms;
                    r_state <= S_PF;
                end
                S_PF: r_state <= S_PF2;
                S_PF2: begin
                    r_head <= r_ins;
                    if (r_count == '0) begin
                        r_tail <= r_ins;
                    end
                    r_valid[r_ins] <= 1'b1;
                    r_count        <= r_count + 1'b1;
                    r_state        <= (r_kind == KIND_PUT) ? S_TRIM : S_FIN;
                end
                S_TRIM: begin
                    if (trim_need) begin
                        r_us      <= r_tail;
                        r_removed <= r_removed + 1'b1;
                        r_ret     <= S_TRIM;
                        r_state   <= S_UL_RD;
                    end else begin
                        r_state <= S_AGE_RD;
                    end
                end
                S_AGE_RD: begin
                    r_state <= (r_count == '0 || r_expiry == '0) ? S_FIN : S_AGE_WAIT;
                end
                S_AGE_WAIT: begin
                    if (is_stale(ent_rd_stamp, r_expiry, r_now)) begin
                        r_us      <= r_tail;
                        r_removed <= r_removed + 1'b1;
                        r_ret     <= S_AGE_RD;
                        r_state   <= S_UL_RD;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    o_done          <= 1'b1;
                    r_o_key_present <= r_present;
                    r_o_hit         <= r_hitf;
                    r_o_read_value  <= r_rdata;
                    r_o_removed     <= sat_count(32'(r_removed));
                    r_o_occ         <= sat_count(32'(r_count));
                    r_state         <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy            = (r_state != S_IDLE);
    assign o_key_present   = r_o_key_present;
    assign o_hit           = r_o_hit;
    assign o_read_value    = r_o_read_value;
    assign o_removed_count = r_o_removed;
    assign o_occupancy     = r_o_occ;

    `LCE_ASSERT(a_count_cap, i_clk, i_rst_n, r_count <= CNT_FULL)
    `LCE_ASSERT_IMP(a_count_map, i_clk, i_rst_n, r_state == S_IDLE,
        $countones(r_valid) == 32'(r_count))
    `LCE_ASSERT_IMP(a_ends_valid, i_clk, i_rst_n, (r_state == S_IDLE) && (r_count != '0),
        r_valid[r_head] && r_valid[r_tail])
    `LCE_ASSERT_NXT(a_one_strobe, i_clk, i_rst_n, o_done, !o_done)

endmodule

// ===== test/tb_lru_cache_with_expiry_unit.sv =====
// testbench of the lru cache with expiry unit: random and directed requests
// checked against an in-bench cache model; depends on lce_pkg and the rtl
`timescale 1ns / 100ps
module tb_lru_cache_with_expiry_unit;
    import lce_pkg::*;

    localparam int SLOTS = 64;

    typedef struct {
        logic [2:0]  kind;
        logic [63:0] key;
        logic [63:0] value;
        logic [31:0] now;
    } req_t;

    typedef struct {
        logic        present;
        logic        hit;
        logic [63:0] rdata;
        logic [6:0]  removed;
        logic [6:0]  occ;
    } result_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] i_kind = '0;
    logic [63:0] i_key = '0;
    logic [63:0] i_value = '0;
    logic [31:0] i_now = '0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_LIMIT;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    logic o_done, o_key_present, o_hit;
    logic [63:0] o_read_value;
    logic [6:0] o_removed_count, o_occupancy;

    lru_cache_with_expiry_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_kind(i_kind), .i_key(i_key), .i_value(i_value), .i_now(i_now),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .o_done(o_done), .o_key_present(o_key_present), .o_hit(o_hit),
        .o_read_value(o_read_value), .o_removed_count(o_removed_count),
        .o_occupancy(o_occupancy)
    );

    always #10 i_clk = ~i_clk;

    // cache model state
    bit          slot_used [SLOTS];
    logic [63:0] slot_tag [SLOTS];
    logic [63:0] slot_val [SLOTS];
    logic [31:0] slot_seen [SLOTS];
    int          slot_rank [SLOTS];
    int          live = 0;
    int          limit_cfg = 0;
    logic [31:0] expiry_cfg = '0;
    bit          no_touch_cfg = 0;

    req_t    request_queue[$];
    result_t expected_results[$];
    int      idle_pct = 0;
    int      errors = 0;
    int      accepted = 0;
    int      hits_seen = 0;
    int      settings_run = 0;
    logic [31:0] clock_now = '0;

    function automatic int find_key(logic [63:0] k);
        int f;
        f = -1;
        for (int i = 0; i < SLOTS; i++)
            if (f < 0 && slot_used[i] && slot_tag[i] == k) f = i;
        return f;
    endfunction

    function automatic int find_lru();
        int f;
        f = -1;
        for (int i = 0; i < SLOTS; i++)
            if (f < 0 && slot_used[i] && slot_rank[i] == live - 1) f = i;
        return f;
    endfunction

    function automatic void drop_slot(int s);
        int r;
        r = slot_rank[s];
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_rank[i] > r) slot_rank[i]--;
        slot_used[s] = 0;
        live--;
    endfunction

    function automatic bit stale(int s, logic [31:0] now);
        return expiry_cfg != 0 &&
               ({1'b0, slot_seen[s]} + {1'b0, expiry_cfg}) < {1'b0, now};
    endfunction

    function automatic int trim_and_age(logic [31:0] now);
        int c, s;
        c = 0;
        if (limit_cfg > 0)
            while (live > limit_cfg && find_lru() >= 0) begin
                drop_slot(find_lru());
                c++;
            end
        s = find_lru();
        while (s >= 0 && stale(s, now)) begin
            drop_slot(s);
            c++;
            s = find_lru();
        end
        return c;
    endfunction

    function automatic result_t cache_apply(req_t r);
        result_t o;
        int s, rem, r0;
        o.present = 0;
        o.hit = 0;
        o.rdata = '0;
        rem = 0;
        case (r.kind)
            KIND_PUT: begin
                s = find_key(r.key);
                if (s >= 0) drop_slot(s);
                if (live >= SLOTS) begin
                    s = find_lru();
                    if (s >= 0) begin
                        drop_slot(s);
                        rem++;
                    end
                end
                s = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (s < 0 && !slot_used[i]) s = i;
                if (s >= 0) begin
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_used[i]) slot_rank[i]++;
                    slot_used[s] = 1;
                    slot_tag[s] = r.key;
                    slot_val[s] = r.value;
                    slot_seen[s] = r.now;
                    slot_rank[s] = 0;
                    live++;
                end
                rem += trim_and_age(r.now);
            end
            KIND_GET: begin
                s = find_key(r.key);
                if (s >= 0) begin
                    o.present = 1;
                    if (stale(s, r.now)) begin
                        drop_slot(s);
                        rem = 1;
                    end else begin
                        o.hit = 1;
                        o.rdata = slot_val[s];
                        if (!no_touch_cfg) begin
                            r0 = slot_rank[s];
                            for (int i = 0; i < SLOTS; i++)
                                if (slot_used[i] && i != s && slot_rank[i] < r0)
                                    slot_rank[i]++;
                            slot_rank[s] = 0;
                            slot_seen[s] = r.now;
                        end
                    end
                end
            end
            KIND_DEL: begin
                s = find_key(r.key);
                if (s >= 0) begin
                    drop_slot(s);
                    rem = 1;
                end
            end
            KIND_CLEAN: rem = trim_and_age(r.now);
            KIND_FLUSH: begin
                rem = live;
                for (int i = 0; i < SLOTS; i++) slot_used[i] = 0;
                live = 0;
            end
            default: ;
        endcase
        o.removed = rem > 127 ? 7'd127 : rem[6:0];
        o.occ = live > 127 ? 7'd127 : live[6:0];
        return o;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                expected_results.push_back(cache_apply('{i_kind, i_key, i_value, i_now}));
                accepted++;
            end
            if (!start || !busy) begin
                if (request_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    req_t r;
                    r = request_queue.pop_front();
                    start <= 1'b1;
                    i_kind <= r.kind;
                    i_key <= r.key;
                    i_value <= r.value;
                    i_now <= r.now;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                $error("result with no request pending");
                errors++;
            end else begin
                result_t e;
                e = expected_results.pop_front();
                if (o_hit) hits_seen++;
                if (o_key_present !== e.present) begin
                    $error("key_present exp %0d got %0d", e.present, o_key_present);
                    errors++;
                end
                if (o_hit !== e.hit) begin
                    $error("hit exp %0d got %0d", e.hit, o_hit);
                    errors++;
                end
                if (o_read_value !== e.rdata) begin
                    $error("read_value exp %h got %h", e.rdata, o_read_value);
                    errors++;
                end
                if (o_removed_count !== e.removed) begin
                    $error("removed_count exp %0d got %0d", e.removed, o_removed_count);
                    errors++;
                end
                if (o_occupancy !== e.occ) begin
                    $error("occupancy exp %0d got %0d", e.occ, o_occupancy);
                    errors++;
                end
            end
        end
    end

    task automatic wait_idle();
        while (request_queue.size() > 0 || start || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_LIMIT:    limit_cfg = int'(data[6:0]);
            CFG_EXPIRY:   expiry_cfg = data;
            CFG_NO_TOUCH: no_touch_cfg = data[0];
            default: ;
        endcase
    endtask

    task automatic set_mode(int lim, logic [31:0] exp, bit nt);
        write_reg(CFG_LIMIT, 32'(lim));
        write_reg(CFG_EXPIRY, exp);
        write_reg(CFG_NO_TOUCH, 32'(nt));
        settings_run++;
    endtask

    task automatic queue_req(logic [2:0] k, logic [63:0] key, logic [63:0] v, logic [31:0] t);
        request_queue.push_back('{k, key, v, t});
    endtask

    task automatic queue_random(int n, int pool);
        int pick;
        logic [2:0] k;
        logic [63:0] key;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 42) k = KIND_PUT;
            else if (pick < 77) k = KIND_GET;
            else if (pick < 87) k = KIND_DEL;
            else if (pick < 95) k = KIND_CLEAN;
            else if (pick < 97) k = KIND_FLUSH;
            else k = 3'($urandom_range(5, 7));
            if ($urandom_range(19) == 0) key = {$urandom, $urandom};
            else key = 64'hA5A5_0000_0000_0000 ^ 64'($urandom_range(pool - 1));
            if ($urandom_range(19) == 0) clock_now = $urandom;
            else clock_now += $urandom_range(0, 3);
            queue_req(k, key, {$urandom, $urandom}, clock_now);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        set_mode(0, 5, 0);
        queue_req(KIND_GET, 64'd0, '0, 32'd0);
        queue_req(KIND_PUT, 64'd0, '1, 32'd0);
        queue_req(KIND_PUT, '1, '0, 32'd1);
        queue_req(KIND_GET, 64'd0, '0, 32'd2);
        queue_req(KIND_GET, '1, '0, 32'd3);
        queue_req(KIND_PUT, '1, 64'h0123_4567_89AB_CDEF, 32'd4);
        queue_req(KIND_GET, '1, '0, 32'd5);
        queue_req(KIND_GET, 64'd0, '0, 32'd20);
        queue_req(KIND_DEL, '1, '0, 32'd20);
        queue_req(KIND_DEL, '1, '0, 32'd20);
        queue_req(KIND_PUT, 64'd7, 64'd7, 32'd20);
        queue_req(KIND_PUT, 64'd8, 64'd8, 32'd21);
        queue_req(KIND_CLEAN, '0, '0, 32'd26);
        queue_req(KIND_CLEAN, '0, '0, 32'd40);
        queue_req(KIND_PUT, 64'd9, 64'd9, 32'hFFFF_FFFF);
        queue_req(KIND_PUT, 64'd10, 64'd10, 32'hFFFF_FFFF);
        queue_req(3'd5, 64'd9, '1, 32'd0);
        queue_req(3'd6, '0, '0, 32'd0);
        queue_req(3'd7, '1, '1, '1);
        queue_req(KIND_FLUSH, '0, '0, '1);
        queue_req(KIND_FLUSH, '0, '0, '1);
        wait_idle();

        idle_pct = 35;
        set_mode(0, 0, 0);
        queue_random(275, 100);
        wait_idle();
        set_mode(64, 20, 1);
        queue_random(275, 80);
        wait_idle();
        idle_pct = 74;
        set_mode(1, 3, 0);
        queue_random(275, 4);
        wait_idle();
        set_mode(127, 32'hFFFF_FFFF, 0);
        queue_random(275, 90);
        wait_idle();
        idle_pct = 0;
        set_mode(8, 10, 1);
        queue_random(275, 16);
        wait_idle();
        set_mode(40, 0, 0);
        queue_random(275, 70);
        wait_idle();

        repeat (400) @(posedge i_clk);
        $display("covered %0d requests under %0d register settings, %0d hits",
                 accepted, settings_run, hits_seen);
        if (errors == 0 && expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #(64'd200_000_000);
        $display("tb: failure");
        $finish;
    end
endmodule
